[sv/bblur_pkg.sv]
// Shared types and constants of the clipped 3x3 box blur.
`default_nettype none

package bblur_pkg;

    // Pixel and position formats.
    localparam int NCH   = 3;
    localparam int PIX_W = 16;
    localparam int POS_W = 10;
    localparam int CFG_W = 11;

    // Column sums over one, two and three rows.
    localparam int S1_W = 16;
    localparam int S2_W = 17;
    localparam int S3_W = 18;

    // Minimum and reset width of the image.
    localparam int MIN_WIDTH   = 3;
    localparam int RESET_WIDTH = 1024;

    // Job queue between the front and back ends.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef logic [NCH-1:0][PIX_W-1:0] pix_t;

    // Sums of one source column over the last three, two and one rows.
    typedef struct packed {
        logic [S3_W-1:0] s3;
        logic [S2_W-1:0] s2;
        logic [S1_W-1:0] s1;
    } hsum_t;

    typedef hsum_t [NCH-1:0] colsum_t;

    // Everything the back end needs to produce the results of one pixel.
    typedef struct packed {
        colsum_t [2:0]    cols;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last_row;
        logic             last_col;
    } job_t;

    // Push side of the job queue.
    typedef struct packed {
        logic push;
        job_t job;
    } qpush_t;

endpackage

`default_nettype wire

[sv/bblur_front.sv]
// Front end: pixel intake, position counters, line store and column sums.
`default_nettype none

module bblur_front
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [PIX_W-1:0]  s_in_red,
    input  wire logic [PIX_W-1:0]  s_in_green,
    input  wire logic [PIX_W-1:0]  s_in_blue,
    input  wire logic [QCNT_W-1:0] q_count,
    output qpush_t                 q_wr
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RST_W = (MAX_WIDTH < RESET_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

    // One line entry holds the two previous rows of a column.
    typedef struct packed {
        pix_t mid;
        pix_t up;
    } line_t;

    line_t line_mem [MAX_WIDTH];

    logic [WW-1:0] width_reg, width_next;
    logic [CW-1:0] row_cnt_reg, col_cnt_reg;
    logic          s_fire;
    logic          col_last, row_last;

    logic             p1_valid_reg;
    pix_t             p1_px_reg;
    logic [CW-1:0]    p1_addr_reg;
    logic             p1_emit_reg;
    logic             p1_last_row_reg;
    logic             p1_last_col_reg;
    logic [POS_W-1:0] p1_row_reg;
    logic [POS_W-1:0] p1_col_reg;
    line_t            rd_reg;

    colsum_t col_a_reg, col_b_reg;
    colsum_t new_col;

    // Room is reserved for the pixel already in flight.
    assign s_ready = (q_count + QCNT_W'(p1_valid_reg)) < QCNT_W'(QDEPTH);
    assign s_fire  = s_valid && s_ready;

    assign col_last = (WW'(col_cnt_reg) == width_reg - WW'(1));
    assign row_last = (WW'(row_cnt_reg) == width_reg - WW'(1));

    // Clamp a written width to the supported range.
    always_comb begin
        if (32'(cfg_wr_data) < 32'(MIN_WIDTH)) begin
            width_next = WW'(MIN_WIDTH);
        end else if (32'(cfg_wr_data) > 32'(MAX_WIDTH)) begin
            width_next = WW'(MAX_WIDTH);
        end else begin
            width_next = WW'(cfg_wr_data);
        end
    end

    // Width register and raster position; a width write restarts the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WW'(RST_W);
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else if (cfg_wr_en) begin
            width_reg   <= width_next;
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else if (s_fire) begin
            if (col_last) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= row_last ? '0 : row_cnt_reg + CW'(1);
            end else begin
                col_cnt_reg <= col_cnt_reg + CW'(1);
            end
        end
    end

    // Intake stage valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= s_fire;
        end
    end

    // Intake stage payload, classified by position.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_px_reg       <= {s_in_blue, s_in_green, s_in_red};
            p1_addr_reg     <= col_cnt_reg;
            p1_emit_reg     <= (row_cnt_reg >= CW'(2)) && (col_cnt_reg >= CW'(2));
            p1_last_row_reg <= row_last;
            p1_last_col_reg <= col_last;
            p1_row_reg      <= POS_W'(row_cnt_reg) - POS_W'(2);
            p1_col_reg      <= POS_W'(col_cnt_reg) - POS_W'(2);
        end
    end

    // Line store: read on intake, rotate the column's rows one stage later.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rd_reg <= line_mem[col_cnt_reg];
        end
        if (p1_valid_reg) begin
            line_mem[p1_addr_reg] <= '{mid: p1_px_reg, up: rd_reg.mid};
        end
    end

    // Sums of the current column over one, two and three rows.
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            new_col[ch].s1 = p1_px_reg[ch];
            new_col[ch].s2 = S2_W'(rd_reg.mid[ch]) + S2_W'(p1_px_reg[ch]);
            new_col[ch].s3 = S3_W'(rd_reg.up[ch]) + S3_W'(rd_reg.mid[ch])
                           + S3_W'(p1_px_reg[ch]);
        end
    end

    // The two previous columns of the window.
    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            col_a_reg <= col_b_reg;
            col_b_reg <= new_col;
        end
    end

    // A pixel with a complete window becomes a job.
    always_comb begin
        q_wr.push         = p1_valid_reg && p1_emit_reg;
        q_wr.job.cols     = {new_col, col_b_reg, col_a_reg};
        q_wr.job.row      = p1_row_reg;
        q_wr.job.col      = p1_col_reg;
        q_wr.job.last_row = p1_last_row_reg;
        q_wr.job.last_col = p1_last_col_reg;
    end

endmodule

`default_nettype wire

[sv/bblur_queue.sv]
// Job queue that decouples the front end from the back end.
`default_nettype none

module bblur_queue
    import bblur_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire qpush_t       q_wr,
    input  wire logic         pop,
    output job_t              head,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (q_wr.push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({q_wr.push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Job storage.
    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            slot_reg[wr_ptr_reg] <= q_wr.job;
        end
    end

endmodule

`default_nettype wire

[sv/bblur_back.sv]
// Back end: walks the results of each job, averages and registers them.
`default_nettype none

module bblur_back
    import bblur_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire job_t              head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [PIX_W-1:0]       m_out_red,
    output logic [PIX_W-1:0]       m_out_green,
    output logic [PIX_W-1:0]       m_out_blue,
    output logic [POS_W-1:0]       m_out_row,
    output logic [POS_W-1:0]       m_out_col,
    output logic                   m_run_last
);

    localparam int WIN_W   = 20;
    localparam int RCP_W   = 24;
    localparam int RCP_SH  = 23;
    localparam int PROD_W  = WIN_W + RCP_W;

    // Reciprocals scaled by 2^23; exact for window sums below 2^20.
    localparam logic [RCP_W-1:0] RCP_DIV1 = 24'd8388608;
    localparam logic [RCP_W-1:0] RCP_DIV2 = 24'd4194304;
    localparam logic [RCP_W-1:0] RCP_DIV3 = 24'd2796203;
    localparam logic [RCP_W-1:0] RCP_DIV4 = 24'd2097152;
    localparam logic [RCP_W-1:0] RCP_DIV6 = 24'd1398102;
    localparam logic [RCP_W-1:0] RCP_DIV9 = 24'd932068;

    // Reciprocal of rows times columns inside the image.
    function automatic logic [RCP_W-1:0] recip(input logic [1:0] h, input logic [1:0] n);
        logic [RCP_W-1:0] r;
        unique case ({h, n}) inside
            4'b1111:          r = RCP_DIV9;
            4'b1110, 4'b1011: r = RCP_DIV6;
            4'b1010:          r = RCP_DIV4;
            4'b1101, 4'b0111: r = RCP_DIV3;
            4'b1001, 4'b0110: r = RCP_DIV2;
            default:          r = RCP_DIV1;
        endcase
        return r;
    endfunction

    // Column sum over the rows that the row step leaves inside the window.
    function automatic logic [WIN_W-1:0] pick(input hsum_t s, input logic [1:0] ri);
        logic [WIN_W-1:0] v;
        case (ri)
            2'd0:    v = WIN_W'(s.s3);
            2'd1:    v = WIN_W'(s.s2);
            default: v = WIN_W'(s.s1);
        endcase
        return v;
    endfunction

    logic       adv, issue, row_done, col_done, run_end;
    logic [1:0] ri_reg, ci_reg;
    logic [1:0] h, n;
    logic [NCH-1:0][WIN_W-1:0] win_sum;

    logic                      y_valid_reg;
    logic [NCH-1:0][WIN_W-1:0] y_sum_reg;
    logic [RCP_W-1:0]          y_rcp_reg;
    logic [POS_W-1:0]          y_row_reg, y_col_reg;
    logic                      y_last_reg;
    logic [NCH-1:0][PIX_W-1:0] quot;

    logic                      m_valid_reg;
    logic [NCH-1:0][PIX_W-1:0] m_pix_reg;
    logic [POS_W-1:0]          m_row_reg, m_col_reg;
    logic                      m_last_reg;

    // The whole back pipeline moves when the output register is free.
    assign adv      = !m_valid_reg || m_ready;
    assign issue    = adv && !empty;
    assign h        = 2'd3 - ri_reg;
    assign n        = 2'd3 - ci_reg;
    assign row_done = (ri_reg == (head.last_row ? 2'd2 : 2'd0));
    assign col_done = (ci_reg == (head.last_col ? 2'd2 : 2'd0));
    assign run_end  = row_done && col_done;
    assign pop      = issue && run_end;

    // Window sum: the columns from the current step to the right edge.
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            win_sum[ch] = '0;
            for (int k = 0; k < 3; k++) begin
                if (2'(k) >= ci_reg) begin
                    win_sum[ch] = win_sum[ch] + pick(head.cols[k][ch], ri_reg);
                end
            end
        end
    end

    // Result walk over rows, then columns within a row.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ri_reg <= '0;
            ci_reg <= '0;
        end else if (issue) begin
            if (col_done) begin
                ci_reg <= '0;
                ri_reg <= row_done ? 2'd0 : ri_reg + 2'd1;
            end else begin
                ci_reg <= ci_reg + 2'd1;
            end
        end
    end

    // Sum stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_valid_reg <= 1'b0;
        end else if (adv) begin
            y_valid_reg <= !empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_sum_reg  <= win_sum;
            y_rcp_reg  <= recip(h, n);
            y_row_reg  <= head.row + POS_W'(ri_reg);
            y_col_reg  <= head.col + POS_W'(ci_reg);
            y_last_reg <= run_end;
        end
    end

    // Division by reciprocal multiply, one multiplier per channel.
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            quot[ch] = PIX_W'((PROD_W'(y_sum_reg[ch]) * PROD_W'(y_rcp_reg)) >> RCP_SH);
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= y_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pix_reg  <= quot;
            m_row_reg  <= y_row_reg;
            m_col_reg  <= y_col_reg;
            m_last_reg <= y_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_pix_reg[0];
    assign m_out_green = m_pix_reg[1];
    assign m_out_blue  = m_pix_reg[2];
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_run_last  = m_last_reg;

endmodule

`default_nettype wire

[sv/box_blur_3x3_clipped.sv]
// Top level of the streaming 3x3 box blur with clipped edge windows.
//
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_valid / s_ready    one source pixel, raster order
//   m_*       out        m_valid / m_ready    one averaged pixel with position
//   cfg_*     in         cfg_wr_en            image width, restarts the frame
//
// The front end takes one pixel per cycle and the back end emits one result per
// cycle, each while its ready is high, so a pixel with k results (up to nine)
// holds the back end until they leave. Results pass the intake stage, the job
// queue and the sum stage to the output register. A four-entry job queue absorbs
// edge bursts; s_ready drops once the queued jobs and the pixel in the intake
// stage fill it. Reset is synchronous; the line store needs no clearing pass.
`default_nettype none

module box_blur_3x3_clipped
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [PIX_W-1:0]  s_in_red,
    input  wire logic [PIX_W-1:0]  s_in_green,
    input  wire logic [PIX_W-1:0]  s_in_blue,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [PIX_W-1:0]       m_out_red,
    output logic [PIX_W-1:0]       m_out_green,
    output logic [PIX_W-1:0]       m_out_blue,
    output logic [POS_W-1:0]       m_out_row,
    output logic [POS_W-1:0]       m_out_col,
    output logic                   m_run_last
);

    qpush_t            q_wr;
    job_t              q_head;
    logic              q_empty;
    logic              q_pop;
    logic [QCNT_W-1:0] q_count;

    // Intake, line store and column sums.
    bblur_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_red    (s_in_red),
        .s_in_green  (s_in_green),
        .s_in_blue   (s_in_blue),
        .q_count     (q_count),
        .q_wr        (q_wr)
    );

    // Jobs waiting for the back end.
    bblur_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty),
        .count   (q_count)
    );

    // Result walk, division and output register.
    bblur_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (q_head),
        .empty       (q_empty),
        .pop         (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_red   (m_out_red),
        .m_out_green (m_out_green),
        .m_out_blue  (m_out_blue),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_run_last  (m_run_last)
    );

endmodule

`default_nettype wire

[sv/bblur_checker.sv]
// Port-level checks of the box blur, bound to its top level.
`default_nettype none

module bblur_checker
    import bblur_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_ready,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic [PIX_W-1:0] m_out_red,
    input wire logic [PIX_W-1:0] m_out_green,
    input wire logic [PIX_W-1:0] m_out_blue,
    input wire logic [POS_W-1:0] m_out_row,
    input wire logic [POS_W-1:0] m_out_col,
    input wire logic             m_run_last
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_red) && $stable(m_out_green)
            && $stable(m_out_blue) && $stable(m_out_row) && $stable(m_out_col)
            && $stable(m_run_last))
        else $error("result payload changed while stalled");

    // Reset empties the pipeline and opens the input.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not empty and ready after reset");

    // The results of one pixel leave as an unbroken burst.
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("gap inside a burst of results");

endmodule

bind box_blur_3x3_clipped bblur_checker u_bblur_checker (.*);

`default_nettype wire
